>>> src/pms_pkg.sv
`default_nettype none
package pms_pkg;

  localparam int MAX_MITER_SCALE = 4;
  localparam int ONE_Q16         = 65536;
  localparam int SCALE_W         = $clog2(MAX_MITER_SCALE * ONE_Q16 + 1);
  localparam int DIVM_QBITS      = $clog2(MAX_MITER_SCALE * MAX_MITER_SCALE) + 33;
  localparam int QUO_W           = DIVM_QBITS;
  localparam longint SAT_LIMIT   =
    ((longint'(1) << 33) + MAX_MITER_SCALE * MAX_MITER_SCALE - 1) /
    (MAX_MITER_SCALE * MAX_MITER_SCALE);

  // datapath operations
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_LATCH      = 5'd1;
  localparam logic [4:0] OP_FIRST      = 5'd2;
  localparam logic [4:0] OP_UV_SEG     = 5'd3;
  localparam logic [4:0] OP_UV_SUM     = 5'd4;
  localparam logic [4:0] OP_NORM       = 5'd5;
  localparam logic [4:0] OP_SQ_A       = 5'd6;
  localparam logic [4:0] OP_SQ_B       = 5'd7;
  localparam logic [4:0] OP_SQRT_UV    = 5'd8;
  localparam logic [4:0] OP_DIV_A      = 5'd9;
  localparam logic [4:0] OP_SAVE_QA    = 5'd10;
  localparam logic [4:0] OP_DIV_B      = 5'd11;
  localparam logic [4:0] OP_UV_WR      = 5'd12;
  localparam logic [4:0] OP_JOINT      = 5'd13;
  localparam logic [4:0] OP_DOT_A      = 5'd14;
  localparam logic [4:0] OP_DOT_B      = 5'd15;
  localparam logic [4:0] OP_MOP        = 5'd16;
  localparam logic [4:0] OP_SAT        = 5'd17;
  localparam logic [4:0] OP_DIV_M      = 5'd18;
  localparam logic [4:0] OP_SQRT_M     = 5'd19;
  localparam logic [4:0] OP_SAVE_SCALE = 5'd20;
  localparam logic [4:0] OP_D_PN       = 5'd21;
  localparam logic [4:0] OP_END_SETUP  = 5'd22;
  localparam logic [4:0] OP_OFF_A      = 5'd23;
  localparam logic [4:0] OP_OFF_B      = 5'd24;
  localparam logic [4:0] OP_OFF_C      = 5'd25;
  localparam logic [4:0] OP_OFF_D      = 5'd26;
  localparam logic [4:0] OP_VTX        = 5'd27;
  localparam logic [4:0] OP_COMMIT     = 5'd28;

  typedef struct packed {
    logic [4:0] op;
    logic       sel;
    logic       side;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic uv_zero;
    logic norm_ok;
    logic sqrt_busy;
    logic div_busy;
    logic sat;
    logic sum_zero;
    logic joint_deg;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> src/pms_dp.sv
`default_nettype none
module pms_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pms_pkg::dp_cmd_t  cmd,
  output pms_pkg::dp_stat_t      stat,
  input  wire logic [111:0]      in_tdata,
  input  wire logic              cfg_valid,
  input  wire logic [23:0]       cfg_data,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [111:0]           out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int SW = pms_pkg::SCALE_W;
  localparam int QW = pms_pkg::QUO_W;

  logic [23:0]        hw_r;
  logic signed [31:0] cur_x_r, cur_y_r, cur_z_r;
  logic [15:0]        sidx_r;
  logic signed [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [17:0] pnx_r, pny_r, nx_r, ny_r, dx_r, dy_r;
  logic               zseg_r, deg_r;
  logic [15:0]        vcnt_r;
  logic [33:0]        ma_r, mb_r;
  logic               va_neg_r, vb_neg_r, uvz_r;
  logic [63:0]        p_r, acc_r;
  logic [16:0]        qa_r;
  logic signed [35:0] op_r;
  logic [SW-1:0]      scale_r;
  logic [31:0]        ox_r, oy_r;
  logic [63:0]        sn_r, sr_r, sbit_r;
  logic               sbusy_r;
  logic [34:0]        rem_r;
  logic [63:0]        dvd_r;
  logic [33:0]        dvs_r;
  logic [QW-1:0]      quo_r;
  logic [5:0]         dcnt_r;
  logic               dbusy_r;
  logic               ov_r;
  logic [111:0]       od_r;
  logic [1:0]         ou_r;
  logic               ol_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               mul_en;
  logic [33:0]        m_max;
  logic signed [33:0] va, vb;
  logic signed [18:0] sum_x, sum_y;
  logic signed [17:0] dc;
  logic [17:0]        dabs;
  logic [63:0]        tot, rnd;
  logic [63:0]        strial;
  logic [35:0]        dtrial;
  logic [47:0]        nm;
  logic [16:0]        qsel;
  logic signed [17:0] ra, rb;
  logic signed [31:0] ptx, pty, ptz;
  logic signed [33:0] vx, vy, ofx, ofy;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end
    return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  assign m_max = (ma_r > mb_r) ? ma_r : mb_r;
  assign sum_x = 19'(pnx_r) + 19'(nx_r);
  assign sum_y = 19'(pny_r) + 19'(ny_r);
  assign dc    = cmd.sel ? dy_r : dx_r;
  assign dabs  = (dc < 0) ? 18'(-dc) : 18'(dc);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      pms_pkg::OP_SQ_A: begin
        mul_a = $signed(33'(ma_r[30:0]));
        mul_b = $signed(33'(ma_r[30:0]));
      end
      pms_pkg::OP_SQ_B: begin
        mul_a = $signed(33'(mb_r[30:0]));
        mul_b = $signed(33'(mb_r[30:0]));
      end
      pms_pkg::OP_DOT_A: begin
        mul_a = 33'(pnx_r);
        mul_b = 33'(nx_r);
      end
      pms_pkg::OP_DOT_B: begin
        mul_a = 33'(pny_r);
        mul_b = 33'(ny_r);
      end
      pms_pkg::OP_OFF_A: begin
        mul_a = $signed(33'(dabs[16:0]));
        mul_b = $signed(33'(hw_r));
      end
      pms_pkg::OP_OFF_B: begin
        mul_a = $signed(33'(p_r[20:0]));
        mul_b = $signed(33'(scale_r));
      end
      pms_pkg::OP_OFF_C: begin
        mul_a = $signed(33'(acc_r[40:21]));
        mul_b = $signed(33'(scale_r));
      end
      default: mul_en = 1'b0;
    endcase
  end
  assign prod = mul_a * mul_b;

  // low part plus high part shifted back, rounded half up
  assign tot = acc_r + {p_r[42:0], 21'b0};
  assign rnd = tot + 64'h8000_0000;

  assign va = (cmd.op == pms_pkg::OP_UV_SEG) ? (34'(cur_y_r) - 34'(prev_y_r)) : 34'(sum_x);
  assign vb = (cmd.op == pms_pkg::OP_UV_SEG) ? (34'(prev_x_r) - 34'(cur_x_r)) : 34'(sum_y);

  assign strial = sr_r + sbit_r;
  assign dtrial = {rem_r, dvd_r[63]};
  assign nm = 48'({ma_r[30:0], 16'b0}) + 48'(sr_r[32:1]);
  logic [47:0] nmb;
  assign nmb = 48'({mb_r[30:0], 16'b0}) + 48'(sr_r[32:1]);

  assign qsel = quo_r[16:0];
  assign ra = uvz_r ? 18'sd0 : (va_neg_r ? -$signed(18'(qa_r)) : $signed(18'(qa_r)));
  assign rb = uvz_r ? 18'sd0 : (vb_neg_r ? -$signed(18'(qsel)) : $signed(18'(qsel)));

  assign ptx = cmd.sel ? cur_x_r : prev_x_r;
  assign pty = cmd.sel ? cur_y_r : prev_y_r;
  assign ptz = cmd.sel ? cur_z_r : prev_z_r;
  assign ofx = (dx_r < 0) ? -$signed(34'(ox_r)) : $signed(34'(ox_r));
  assign ofy = (dy_r < 0) ? -$signed(34'(oy_r)) : $signed(34'(oy_r));
  assign vx  = cmd.side ? (34'(ptx) - ofx) : (34'(ptx) + ofx);
  assign vy  = cmd.side ? (34'(pty) - ofy) : (34'(pty) + ofy);

  always_comb begin
    stat.uv_zero   = uvz_r;
    stat.norm_ok   = (m_max[33:31] == 3'b000) && m_max[30];
    stat.sqrt_busy = sbusy_r;
    stat.div_busy  = dbusy_r;
    stat.sat       = op_r[35] || (op_r == 36'sd0) ||
                     (op_r[34:0] < 35'(pms_pkg::SAT_LIMIT));
    stat.sum_zero  = (sum_x == 19'sd0) && (sum_y == 19'sd0);
    stat.joint_deg = ((pnx_r == 18'sd0) && (pny_r == 18'sd0)) || zseg_r;
    stat.out_busy  = ov_r && !out_tready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r    <= 24'(pms_pkg::ONE_Q16);
      sbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
      ov_r    <= 1'b0;
      vcnt_r  <= '0;
    end else begin
      if (cfg_valid) begin
        hw_r <= cfg_data;
      end
      if (cmd.op == pms_pkg::OP_SQRT_UV || cmd.op == pms_pkg::OP_SQRT_M) begin
        sbusy_r <= 1'b1;
      end else if (sbusy_r) begin
        sbusy_r <= !sbit_r[0];
      end
      if (cmd.op == pms_pkg::OP_DIV_A || cmd.op == pms_pkg::OP_DIV_B ||
          cmd.op == pms_pkg::OP_DIV_M) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r) begin
        dbusy_r <= (dcnt_r != 6'd1);
      end
      if (cmd.op == pms_pkg::OP_VTX) begin
        ov_r   <= 1'b1;
        vcnt_r <= vcnt_r + 16'd1;
      end else begin
        if (out_tready) begin
          ov_r <= 1'b0;
        end
        if (cmd.op == pms_pkg::OP_FIRST) begin
          vcnt_r <= sidx_r;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_r <= prod[63:0];
    end
    if (cmd.op == pms_pkg::OP_SQ_B || cmd.op == pms_pkg::OP_DOT_B ||
        cmd.op == pms_pkg::OP_OFF_B || cmd.op == pms_pkg::OP_OFF_C) begin
      acc_r <= p_r;
    end
    if (cmd.op == pms_pkg::OP_LATCH) begin
      cur_x_r <= $signed(in_tdata[31:0]);
      cur_y_r <= $signed(in_tdata[63:32]);
      cur_z_r <= $signed(in_tdata[95:64]);
      sidx_r  <= in_tdata[111:96];
    end
    if (cmd.op == pms_pkg::OP_FIRST || cmd.op == pms_pkg::OP_COMMIT) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
      prev_z_r <= cur_z_r;
    end
    if (cmd.op == pms_pkg::OP_COMMIT) begin
      pnx_r <= nx_r;
      pny_r <= ny_r;
    end
    if (cmd.op == pms_pkg::OP_UV_SEG || cmd.op == pms_pkg::OP_UV_SUM) begin
      va_neg_r <= va[33];
      vb_neg_r <= vb[33];
      ma_r     <= va[33] ? 34'(-va) : 34'(va);
      mb_r     <= vb[33] ? 34'(-vb) : 34'(vb);
      uvz_r    <= (va == 34'sd0) && (vb == 34'sd0);
    end else if (cmd.op == pms_pkg::OP_NORM) begin
      if (m_max[33:31] != 3'b000) begin
        ma_r <= ma_r >> 1;
        mb_r <= mb_r >> 1;
      end else begin
        ma_r <= ma_r << 1;
        mb_r <= mb_r << 1;
      end
    end

    // bit-serial square root, two radicand bits a step
    if (cmd.op == pms_pkg::OP_SQRT_UV || cmd.op == pms_pkg::OP_SQRT_M) begin
      sn_r   <= (cmd.op == pms_pkg::OP_SQRT_UV) ? (acc_r + p_r) : 64'(quo_r);
      sr_r   <= '0;
      sbit_r <= 64'(1) << 62;
    end else if (sbusy_r) begin
      if (sn_r >= strial) begin
        sn_r <= sn_r - strial;
        sr_r <= (sr_r >> 1) + sbit_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end

    // restoring divider, one quotient bit a step
    if (cmd.op == pms_pkg::OP_DIV_A || cmd.op == pms_pkg::OP_DIV_B) begin
      rem_r  <= (cmd.op == pms_pkg::OP_DIV_A) ? 35'(nm[47:18]) : 35'(nmb[47:18]);
      dvd_r  <= (cmd.op == pms_pkg::OP_DIV_A) ? {nm[17:0], 46'b0} : {nmb[17:0], 46'b0};
      dvs_r  <= 34'(sr_r[31:0]);
      dcnt_r <= 6'd18;
      quo_r  <= '0;
    end else if (cmd.op == pms_pkg::OP_DIV_M) begin
      rem_r  <= 35'(1) << (65 - pms_pkg::DIVM_QBITS);
      dvd_r  <= '0;
      dvs_r  <= op_r[33:0];
      dcnt_r <= 6'(pms_pkg::DIVM_QBITS);
      quo_r  <= '0;
    end else if (dbusy_r) begin
      if (dtrial >= 36'(dvs_r)) begin
        rem_r <= 35'(dtrial - 36'(dvs_r));
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= dtrial[34:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      dvd_r  <= dvd_r << 1;
      dcnt_r <= dcnt_r - 6'd1;
    end

    if (cmd.op == pms_pkg::OP_SAVE_QA) begin
      qa_r <= qsel;
    end
    if (cmd.op == pms_pkg::OP_UV_WR) begin
      if (cmd.sel) begin
        dx_r <= ra;
        dy_r <= rb;
      end else begin
        nx_r   <= ra;
        ny_r   <= rb;
        zseg_r <= uvz_r;
      end
    end
    if (cmd.op == pms_pkg::OP_MOP) begin
      op_r <= 36'sh1_0000_0000 + 36'($signed(acc_r)) + 36'($signed(p_r));
    end
    if (cmd.op == pms_pkg::OP_JOINT) begin
      scale_r <= SW'(pms_pkg::ONE_Q16);
      deg_r   <= stat.joint_deg;
    end
    if (cmd.op == pms_pkg::OP_SAT) begin
      scale_r <= SW'(pms_pkg::MAX_MITER_SCALE * pms_pkg::ONE_Q16);
      deg_r   <= 1'b1;
    end
    if (cmd.op == pms_pkg::OP_SAVE_SCALE) begin
      scale_r <= sr_r[SW-1:0];
    end
    if (cmd.op == pms_pkg::OP_D_PN) begin
      dx_r <= pnx_r;
      dy_r <= pny_r;
    end
    if (cmd.op == pms_pkg::OP_END_SETUP) begin
      dx_r    <= nx_r;
      dy_r    <= ny_r;
      scale_r <= SW'(pms_pkg::ONE_Q16);
      deg_r   <= zseg_r;
    end
    if (cmd.op == pms_pkg::OP_OFF_D) begin
      if (cmd.sel) begin
        oy_r <= rnd[63:32];
      end else begin
        ox_r <= rnd[63:32];
      end
    end
    if (cmd.op == pms_pkg::OP_VTX) begin
      od_r <= {vcnt_r, ptz, sat32(vy), sat32(vx)};
      ou_r <= {deg_r, cmd.side};
      ol_r <= cmd.last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule
`default_nettype wire

>>> src/pms_ctrl.sv
`default_nettype none
module pms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tlast,
  output logic                   in_tready,
  output pms_pkg::dp_cmd_t       cmd,
  input  wire pms_pkg::dp_stat_t stat
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FIRST = 5'd1;
  localparam logic [4:0] S_SEG   = 5'd2;
  localparam logic [4:0] S_UVCHK = 5'd3;
  localparam logic [4:0] S_NORM  = 5'd4;
  localparam logic [4:0] S_SQA   = 5'd5;
  localparam logic [4:0] S_SQB   = 5'd6;
  localparam logic [4:0] S_SQS   = 5'd7;
  localparam logic [4:0] S_SQW   = 5'd8;
  localparam logic [4:0] S_DVA   = 5'd9;
  localparam logic [4:0] S_DVAW  = 5'd10;
  localparam logic [4:0] S_DVB   = 5'd11;
  localparam logic [4:0] S_DVBW  = 5'd12;
  localparam logic [4:0] S_UVWR  = 5'd13;
  localparam logic [4:0] S_JOINT = 5'd14;
  localparam logic [4:0] S_DOTA  = 5'd15;
  localparam logic [4:0] S_DOTB  = 5'd16;
  localparam logic [4:0] S_MOP   = 5'd17;
  localparam logic [4:0] S_SATC  = 5'd18;
  localparam logic [4:0] S_DMW   = 5'd19;
  localparam logic [4:0] S_SMW   = 5'd20;
  localparam logic [4:0] S_DIR   = 5'd21;
  localparam logic [4:0] S_ENDS  = 5'd22;
  localparam logic [4:0] S_OFA   = 5'd23;
  localparam logic [4:0] S_OFB   = 5'd24;
  localparam logic [4:0] S_OFC   = 5'd25;
  localparam logic [4:0] S_OFD   = 5'd26;
  localparam logic [4:0] S_V0    = 5'd27;
  localparam logic [4:0] S_V1    = 5'd28;
  localparam logic [4:0] S_DONE  = 5'd29;

  logic [4:0] state_r, state_nxt;
  logic [1:0] ps_r, ps_nxt;
  logic       last_r, last_nxt;
  logic       uv_dest_r, uv_dest_nxt;
  logic       pair_cur_r, pair_cur_nxt;
  logic       comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ps_r       <= '0;
      last_r     <= 1'b0;
      uv_dest_r  <= 1'b0;
      pair_cur_r <= 1'b0;
      comp_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ps_r       <= ps_nxt;
      last_r     <= last_nxt;
      uv_dest_r  <= uv_dest_nxt;
      pair_cur_r <= pair_cur_nxt;
      comp_r     <= comp_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ps_nxt       = ps_r;
    last_nxt     = last_r;
    uv_dest_nxt  = uv_dest_r;
    pair_cur_nxt = pair_cur_r;
    comp_nxt     = comp_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.op       = pms_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = pms_pkg::OP_LATCH;
          last_nxt  = in_tlast;
          state_nxt = (ps_r == 2'd0) ? S_FIRST : S_SEG;
        end
      end
      S_FIRST: begin
        cmd.op    = pms_pkg::OP_FIRST;
        ps_nxt    = last_r ? 2'd0 : 2'd1;
        state_nxt = S_IDLE;
      end
      S_SEG: begin
        cmd.op       = pms_pkg::OP_UV_SEG;
        uv_dest_nxt  = 1'b0;
        pair_cur_nxt = 1'b0;
        state_nxt    = S_UVCHK;
      end
      S_UVCHK: state_nxt = stat.uv_zero ? S_UVWR : S_NORM;
      S_NORM: begin
        if (stat.norm_ok) begin
          state_nxt = S_SQA;
        end else begin
          cmd.op = pms_pkg::OP_NORM;
        end
      end
      S_SQA: begin
        cmd.op    = pms_pkg::OP_SQ_A;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.op    = pms_pkg::OP_SQ_B;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op    = pms_pkg::OP_SQRT_UV;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (!stat.sqrt_busy) begin
          state_nxt = S_DVA;
        end
      end
      S_DVA: begin
        cmd.op    = pms_pkg::OP_DIV_A;
        state_nxt = S_DVAW;
      end
      S_DVAW: begin
        if (!stat.div_busy) begin
          cmd.op    = pms_pkg::OP_SAVE_QA;
          state_nxt = S_DVB;
        end
      end
      S_DVB: begin
        cmd.op    = pms_pkg::OP_DIV_B;
        state_nxt = S_DVBW;
      end
      S_DVBW: begin
        if (!stat.div_busy) begin
          state_nxt = S_UVWR;
        end
      end
      S_UVWR: begin
        cmd.op  = pms_pkg::OP_UV_WR;
        cmd.sel = uv_dest_r;
        if (uv_dest_r) begin
          state_nxt = S_OFA;
        end else if (ps_r == 2'd1) begin
          state_nxt = S_ENDS;
        end else begin
          state_nxt = S_JOINT;
        end
      end
      S_JOINT: begin
        cmd.op    = pms_pkg::OP_JOINT;
        state_nxt = stat.joint_deg ? S_DIR : S_DOTA;
      end
      S_DOTA: begin
        cmd.op    = pms_pkg::OP_DOT_A;
        state_nxt = S_DOTB;
      end
      S_DOTB: begin
        cmd.op    = pms_pkg::OP_DOT_B;
        state_nxt = S_MOP;
      end
      S_MOP: begin
        cmd.op    = pms_pkg::OP_MOP;
        state_nxt = S_SATC;
      end
      S_SATC: begin
        if (stat.sat) begin
          cmd.op    = pms_pkg::OP_SAT;
          state_nxt = S_DIR;
        end else begin
          cmd.op    = pms_pkg::OP_DIV_M;
          state_nxt = S_DMW;
        end
      end
      S_DMW: begin
        if (!stat.div_busy) begin
          cmd.op    = pms_pkg::OP_SQRT_M;
          state_nxt = S_SMW;
        end
      end
      S_SMW: begin
        if (!stat.sqrt_busy) begin
          cmd.op    = pms_pkg::OP_SAVE_SCALE;
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        // exactly reversed segments keep the previous normal as direction
        if (stat.sum_zero) begin
          cmd.op    = pms_pkg::OP_D_PN;
          state_nxt = S_OFA;
        end else begin
          cmd.op      = pms_pkg::OP_UV_SUM;
          uv_dest_nxt = 1'b1;
          state_nxt   = S_UVCHK;
        end
      end
      S_ENDS: begin
        cmd.op    = pms_pkg::OP_END_SETUP;
        state_nxt = S_OFA;
      end
      S_OFA: begin
        cmd.op    = pms_pkg::OP_OFF_A;
        cmd.sel   = comp_r;
        state_nxt = S_OFB;
      end
      S_OFB: begin
        cmd.op    = pms_pkg::OP_OFF_B;
        state_nxt = S_OFC;
      end
      S_OFC: begin
        cmd.op    = pms_pkg::OP_OFF_C;
        state_nxt = S_OFD;
      end
      S_OFD: begin
        cmd.op  = pms_pkg::OP_OFF_D;
        cmd.sel = comp_r;
        if (comp_r) begin
          comp_nxt  = 1'b0;
          state_nxt = S_V0;
        end else begin
          comp_nxt  = 1'b1;
          state_nxt = S_OFA;
        end
      end
      S_V0: begin
        if (!stat.out_busy) begin
          cmd.op    = pms_pkg::OP_VTX;
          cmd.sel   = pair_cur_r;
          state_nxt = S_V1;
        end
      end
      S_V1: begin
        if (!stat.out_busy) begin
          cmd.op   = pms_pkg::OP_VTX;
          cmd.sel  = pair_cur_r;
          cmd.side = 1'b1;
          cmd.last = pair_cur_r || !last_r;
          if (!pair_cur_r && last_r) begin
            pair_cur_nxt = 1'b1;
            state_nxt    = S_ENDS;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        cmd.op    = pms_pkg::OP_COMMIT;
        ps_nxt    = last_r ? 2'd0 : 2'd2;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/polyline_miter_stroker_top.sv
// polyline stroker with miter joins
// in_*: one polyline point per item; in_tlast marks the last point of a line.
//   the first point of a line loads the vertex number from start_index.
// out_*: offset vertices, side 0 (point plus offset) then side 1 (minus).
//   a point's two vertices leave when the following point arrives; the last
//   point of a line sends its own pair as well. out_tlast marks the final
//   vertex caused by an item. a line of one point gives nothing.
// cfg_*: half width write, always ready; write only while the block is idle.
// one item is worked on at a time. its time is set by output stalls, the one-bit
//   normalizing shifter (up to 30 steps), the shared bit-serial square root
//   (32 steps) and the shared restoring divider (18 or 37 steps) in pms_dp.
// the last vertex sits in the output register while the next item is taken.
// when out_tready is low the vertex holds and the controller waits before
//   loading the next one.
// reset (rst_n low, synchronous) sets half width to 1.0, drops any pending
//   vertex and starts a new line.
`default_nettype none
module polyline_miter_stroker_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // point_x, point_y, point_z, start_index
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // vertex_x, vertex_y, vertex_z, vertex_number
  output logic [1:0]        out_tuser,  // side, degenerate
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [23:0]  cfg_data
);

  pms_pkg::dp_cmd_t  cmd;
  pms_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pms_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> src/pms_checker.sv
`default_nettype none
module pms_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic [1:0]   out_tuser,
  input wire logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled vertex changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("vertex pending after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while the previous one is in work");

  a_side0_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tlast)
    else $error("side 0 vertex marked last");

endmodule

bind polyline_miter_stroker_top pms_checker u_pms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

>>> dv/tb_polyline_miter_stroker_top.sv
`default_nettype none
module tb_polyline_miter_stroker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] num;
    logic        side;
    logic        deg;
    logic        last;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = '0;

  polyline_miter_stroker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // stroker state as predicted
  logic [23:0]        half_w;
  logic signed [31:0] prv_x, prv_y, prv_z;
  int                 prv_nx, prv_ny;
  int                 pts_seen;
  logic [15:0]        vtx_count;

  vertex_t vertex_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      no_idle = 0;
  int      hold_cnt = 0;
  // current line, for generating coordinates
  logic [31:0] gen_x, gen_y, gen_px, gen_py;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void unit_dir(input longint a, input longint b, output int ua,
                                   output int ub);
    longint unsigned ma, mb, m, len, qa, qb;
    ma = mag(a);
    mb = mag(b);
    if (ma == 0 && mb == 0) begin
      ua = 0;
      ub = 0;
      return;
    end
    m = ma > mb ? ma : mb;
    while (m < (64'd1 << 30)) begin ma = ma << 1; mb = mb << 1; m = m << 1; end
    while (m >= (64'd1 << 31)) begin ma = ma >> 1; mb = mb >> 1; m = m >> 1; end
    len = isqrt(ma * ma + mb * mb);
    qa = ((ma << 16) + len / 2) / len;
    qb = ((mb << 16) + len / 2) / len;
    ua = a < 0 ? -int'(qa) : int'(qa);
    ub = b < 0 ? -int'(qb) : int'(qb);
  endfunction

  function automatic longint offset_of(int d, longint unsigned sc);
    longint unsigned m;
    longint r;
    m = mag(d) * longint'(half_w) * sc;
    r = longint'((m + (64'd1 << 31)) >> 32);
    return d < 0 ? -r : r;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void push_pair(logic signed [31:0] x, logic signed [31:0] y,
                                    logic [31:0] z, int dx, int dy,
                                    longint unsigned sc, bit deg);
    longint ox, oy;
    vertex_t v;
    ox = offset_of(dx, sc);
    oy = offset_of(dy, sc);
    for (int s = 0; s < 2; s++) begin
      v.x = sat32(s == 0 ? longint'(x) + ox : longint'(x) - ox);
      v.y = sat32(s == 0 ? longint'(y) + oy : longint'(y) - oy);
      v.z = z;
      v.num = vtx_count;
      v.side = s[0];
      v.deg = deg;
      v.last = 1'b0;
      vertex_q.insert(vertex_q.size(), v);
      vtx_count = vtx_count + 16'd1;
    end
  endfunction

  function automatic void stroke_point(logic signed [31:0] x, logic signed [31:0] y,
                                       logic [31:0] z, logic [15:0] idx, bit last);
    int nx, ny, dx, dy;
    bit zseg, deg;
    longint sxx, syy, op;
    longint unsigned sc;
    logic [65:0] quo;
    if (pts_seen == 0) begin
      vtx_count = idx;
      prv_x = x; prv_y = y; prv_z = z;
      pts_seen = last ? 0 : 1;
      return;
    end
    unit_dir(longint'(y) - longint'(prv_y), longint'(prv_x) - longint'(x), nx, ny);
    zseg = (nx == 0 && ny == 0);
    if (pts_seen == 1) begin
      push_pair(prv_x, prv_y, prv_z, nx, ny, pms_pkg::ONE_Q16, zseg);
    end else begin
      sc = pms_pkg::ONE_Q16;
      deg = (prv_nx == 0 && prv_ny == 0) || zseg;
      sxx = longint'(prv_nx) + nx;
      syy = longint'(prv_ny) + ny;
      if (deg) begin
        unit_dir(sxx, syy, dx, dy);
      end else begin
        op = (longint'(1) << 32) + longint'(prv_nx) * nx + longint'(prv_ny) * ny;
        if (op <= 0 || longint'(pms_pkg::MAX_MITER_SCALE * pms_pkg::MAX_MITER_SCALE) * op
                       < (longint'(1) << 33)) begin
          sc = longint'(pms_pkg::MAX_MITER_SCALE) << 16;
          deg = 1;
        end else begin
          quo = (66'd1 << 65) / 66'(op);
          sc = isqrt(quo[63:0]);
        end
        if (sxx == 0 && syy == 0) begin
          dx = prv_nx;
          dy = prv_ny;
        end else begin
          unit_dir(sxx, syy, dx, dy);
        end
      end
      push_pair(prv_x, prv_y, prv_z, dx, dy, sc, deg);
    end
    if (last) begin
      push_pair(x, y, z, nx, ny, pms_pkg::ONE_Q16, zseg);
      pts_seen = 0;
    end else begin
      pts_seen = 2;
    end
    prv_x = x; prv_y = y; prv_z = z;
    prv_nx = nx; prv_ny = ny;
    vertex_q[vertex_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] idx, bit last);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {idx, z, y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    stroke_point(x, y, z, idx, last);
  endtask

  task automatic wait_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [23:0] w);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_w = w;
  endtask

  // next coordinate of a random line: mostly nearby steps, some wild jumps,
  // repeated points and exact returns to the point before
  task automatic next_point(output logic [31:0] x, output logic [31:0] y);
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      x = $urandom;
      y = $urandom;
    end else if (r < 14) begin
      x = gen_x;
      y = gen_y;
    end else if (r < 20) begin
      x = gen_px;
      y = gen_py;
    end else begin
      x = gen_x + ($urandom & ((32'd1 << $urandom_range(22, 4)) - 1))
          - (32'd1 << ($urandom_range(21, 3)));
      y = gen_y + ($urandom & ((32'd1 << $urandom_range(22, 4)) - 1))
          - (32'd1 << ($urandom_range(21, 3)));
    end
    gen_px = gen_x; gen_py = gen_y;
    gen_x = x; gen_y = y;
  endtask

  task automatic random_lines(int n_items);
    int sent, len;
    logic [31:0] x, y;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
      gen_x = $urandom_range(99) < 10 ? $urandom : 32'($urandom_range(2000000)) - 1000000;
      gen_y = $urandom_range(99) < 10 ? $urandom : 32'($urandom_range(2000000)) - 1000000;
      gen_px = gen_x; gen_py = gen_y;
      for (int i = 0; i < len; i++) begin
        if (i == 0) begin
          x = gen_x;
          y = gen_y;
        end else begin
          next_point(x, y);
        end
        send_point(x, y, $urandom, 16'($urandom), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_default_width();
    send_point(32'h0, 32'h0, 32'h11, 16'd5, 1'b0);
    send_point(32'h0a0000, 32'h0, 32'h22, 16'd0, 1'b0);
    send_point(32'h0a0000, 32'h0a0000, 32'h33, 16'd0, 1'b1);
  endtask

  task automatic test_special_cases();
    write_width(24'hffffff);
    // vertices pushed past the coordinate range
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 16'hfffe, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'h0, 16'h0, 1'b1);
    // line of one point
    send_point(32'h1234, 32'h5678, 32'h9, 16'h00ff, 1'b1);
    write_width(24'd0);
    send_point(32'h10000, 32'h20000, 32'h1, 16'h8000, 1'b0);
    send_point(32'h30000, 32'h10000, 32'h2, 16'h0, 1'b1);
    write_width(24'd131072);
    // zero-length segment then a turn
    send_point(32'h0, 32'h0, 32'h1, 16'hffff, 1'b0);
    send_point(32'h0, 32'h0, 32'h2, 16'h0, 1'b0);
    send_point(32'h50000, 32'h0, 32'h3, 16'h0, 1'b0);
    // exact reversal
    send_point(32'h0, 32'h0, 32'h4, 16'h0, 1'b0);
    // sharp miter that saturates
    send_point(32'h50000, 32'h8000, 32'h5, 16'h0, 1'b0);
    // right angle
    send_point(32'h50000, 32'h60000, 32'h6, 16'h0, 1'b1);
    // three equal points: both normals zero
    send_point(32'h40000, 32'h40000, 32'h7, 16'h10, 1'b0);
    send_point(32'h40000, 32'h40000, 32'h8, 16'h0, 1'b0);
    send_point(32'h40000, 32'h40000, 32'h9, 16'h0, 1'b1);
  endtask

  task automatic test_output_backpressure();
    write_width(24'd65536);
    hold_cnt = 3000;
    random_lines(14);
  endtask

  task automatic test_random_points();
    write_width(24'd1);
    random_lines(80);
    write_width(24'($urandom_range(24'h7ffff, 1)));
    random_lines(80);
    write_width(24'hffffff);
    no_idle = 1;
    random_lines(80);
    no_idle = 0;
    write_width(24'($urandom));
    random_lines(80);
    write_width(24'd65536);
    random_lines(65);
  endtask

  // result checker and receiver side
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex %h %b %b", $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (out_tdata != {e.num, e.z, e.y, e.x} || out_tuser != {e.deg, e.side}
            || out_tlast != e.last) begin
          $display("%0t: vertex mismatch, expected %h %b %b, actual %h %b %b", $time,
                   {e.num, e.z, e.y, e.x}, {e.deg, e.side}, e.last,
                   out_tdata, out_tuser, out_tlast);
          errors++;
        end
      end
    end
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_tready <= no_idle || $urandom_range(99) >= 35;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    half_w = 24'd65536;
    prv_x = 0; prv_y = 0; prv_z = 0;
    prv_nx = 0; prv_ny = 0;
    pts_seen = 0;
    vtx_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_width();
    test_special_cases();
    test_output_backpressure();
    test_random_points();
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
